// ===== rtl/glmd_pkg.sv =====
// Shared constants and types of the grid local minimum detector.
package glmd_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 128;
    localparam int LEVEL_W    = 4;
    localparam int LEVEL_MAX  = 9;
    localparam int SIZE_W     = 8;                       // register width
    localparam int COL_W      = $clog2(MAX_COLS);        // column counter
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);    // row counter, reaches rows
    localparam int LINE_LEN   = MAX_COLS - 1;            // cells per row line
    localparam int LINE_IDX_W = $clog2(MAX_COLS);        // entry point, LINE_LEN = bypass
    localparam int COUNT_W    = 15;
    localparam int RISK_W     = 18;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 7;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    typedef logic [LEVEL_W-1:0] level_t;

    // Control of one row line: advance on each processed request, entry cell from frame width.
    typedef struct packed {
        logic                  shift;
        logic [LINE_IDX_W-1:0] entry;
    } line_ctrl_t;

    typedef struct packed {
        logic [RISK_W-1:0]    risk_sum;
        logic [COUNT_W-1:0]   low_count;
        logic                 is_low;
        logic [LEVEL_W-1:0]   centre_level;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } result_t;

endpackage

// ===== rtl/glmd_cell.sv =====
// One storage cell of a row line: takes a new pixel or its neighbor's pixel.
module glmd_cell
    import glmd_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  logic   load_here,
    input  level_t new_level,
    input  level_t chain_level,
    output level_t q
);

    level_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= load_here ? new_level : chain_level;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/glmd_row_line.sv =====
// Row delay line of cells whose length follows the frame width.
module glmd_row_line
    import glmd_pkg::*;
(
    input  logic       clk,
    input  line_ctrl_t ctrl,
    input  level_t     din,
    output level_t     dout
);

    level_t taps [LINE_LEN];

    for (genvar k = 0; k < LINE_LEN; k++)
    begin : g_cell
        localparam logic [LINE_IDX_W-1:0] K = LINE_IDX_W'(k);
        level_t chain_in;

        if (k == 0)
        begin : g_head
            assign chain_in = din;
        end
        else
        begin : g_body
            assign chain_in = taps[k-1];
        end

        glmd_cell u_cell (
            .clk         (clk),
            .shift       (ctrl.shift),
            .load_here   (ctrl.entry == K),
            .new_level   (din),
            .chain_level (chain_in),
            .q           (taps[k])
        );
    end

    // Entry past the last cell means a one-pixel row: zero delay.
    assign dout = (ctrl.entry == LINE_IDX_W'(LINE_LEN)) ? din : taps[LINE_LEN-1];

endmodule

// ===== rtl/grid_local_minimum_detector.sv =====
// Top level of the grid local minimum detector.
// Takes one pixel request per clock while the skid entry is free and returns each
// pixel's verdict one row later; pixels of the first row give no result, and after
// the last row the host sends columns_in_use drain requests, whose last result
// carries tlast and clears the running totals. Two row lines of shift cells hold the
// previous rows, so neighbors are read at fixed taps; a two-entry output buffer keeps
// input flowing while a result waits. Write the size registers only while idle; any
// write restarts the frame. Sizes of 0 act as 1 and sizes above 128 as 128.
module grid_local_minimum_detector
    import glmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    // pixel stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [3:0] level, [7:4] zero
    input  logic              s_tuser,   // [0] drain
    // verdict stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // col, row, centre_level, is_low, low_count,
                                         // risk_sum from bit 0 up, [55:52] zero
    output logic              m_tlast    // frame_end
);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int unsigned mx);
        logic [SIZE_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = SIZE_W'(1);
            end
            else if (v > SIZE_W'(mx))
            begin
                r = SIZE_W'(mx);
            end
            return r;
        end
    endfunction

    logic [SIZE_W-1:0]  cols_reg, rows_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [RISK_W-1:0]  risk_reg;
    level_t             centre_reg, west_reg;

    result_t            out_reg, skid_reg;
    logic               out_last_reg, skid_last_reg;
    logic               out_v_reg, skid_v_reg;

    // ---- request decode ----
    logic       accept, draining, ignore, proc, drn, has_result, low, last;
    level_t     lvl_in, lvl_eff, east, north;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;
    logic [COUNT_W-1:0] count_next;
    logic [RISK_W-1:0]  risk_next;
    logic               wrap;
    line_ctrl_t         ctrl;
    result_t            res;

    assign accept   = s_tvalid && s_tready;
    assign lvl_in   = (s_tdata[LEVEL_W-1:0] > level_t'(LEVEL_MAX))
                      ? level_t'(LEVEL_MAX) : s_tdata[LEVEL_W-1:0];
    assign draining = (in_row_reg >= ROW_W'(rows_reg));
    assign ignore   = s_tuser && !draining;
    assign proc     = accept && !ignore;
    assign drn      = s_tuser || draining;
    assign lvl_eff  = draining ? '0 : lvl_in;
    assign has_result = (in_row_reg != '0);

    assign ctrl = '{shift: proc, entry: LINE_IDX_W'(SIZE_W'(MAX_COLS) - cols_reg)};

    // line a holds the pixels just newer than the centre, line b those older than west
    glmd_row_line u_line_a (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (lvl_eff),
        .dout (east)
    );

    glmd_row_line u_line_b (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (west_reg),
        .dout (north)
    );

    always_comb
    begin
        low = 1'b1;
        if (!drn && !(centre_reg < lvl_eff))
        begin
            low = 1'b0;
        end
        if ((in_row_reg > ROW_W'(1)) && !(centre_reg < north))
        begin
            low = 1'b0;
        end
        if ((in_col_reg != '0) && !(centre_reg < west_reg))
        begin
            low = 1'b0;
        end
        if (((SIZE_W'(in_col_reg) + SIZE_W'(1)) < cols_reg) && !(centre_reg < east))
        begin
            low = 1'b0;
        end
    end

    assign wrap = (SIZE_W'(in_col_reg) + SIZE_W'(1)) >= cols_reg;
    assign last = drn && wrap;

    assign count_next = low ? count_reg + COUNT_W'(1) : count_reg;
    assign risk_next  = low ? risk_reg + RISK_W'(centre_reg) + RISK_W'(1) : risk_reg;
    assign col_next   = wrap ? '0 : in_col_reg + COL_W'(1);
    assign row_next   = wrap ? in_row_reg + ROW_W'(1) : in_row_reg;

    always_comb
    begin
        res.col          = OUT_COL_W'(in_col_reg);
        res.row          = OUT_ROW_W'(in_row_reg - ROW_W'(1));
        res.centre_level = centre_reg;
        res.is_low       = low;
        res.low_count    = count_next;
        res.risk_sum     = risk_next;
    end

    // ---- configuration and frame state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= SIZE_W'(MAX_COLS);
            rows_reg   <= SIZE_W'(MAX_ROWS);
            in_col_reg <= '0;
            in_row_reg <= '0;
            count_reg  <= '0;
            risk_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLUMNS: cols_reg <= clamp_size(cfg_data, MAX_COLS);
                CFG_ROWS:    rows_reg <= clamp_size(cfg_data, MAX_ROWS);
                default:     ;
            endcase
            in_col_reg <= '0;
            in_row_reg <= '0;
            count_reg  <= '0;
            risk_reg   <= '0;
        end
        else if (proc)
        begin
            if (has_result && last)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                count_reg  <= '0;
                risk_reg   <= '0;
            end
            else
            begin
                in_col_reg <= col_next;
                in_row_reg <= row_next;
                if (has_result)
                begin
                    count_reg <= count_next;
                    risk_reg  <= risk_next;
                end
            end
        end
    end

    // centre and west taps sit between the two row lines
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            centre_reg <= east;
            west_reg   <= centre_reg;
        end
    end

    // ---- output register with skid stage ----
    logic m_fire, push;

    assign m_fire = out_v_reg && m_tready;
    assign push   = proc && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_fire)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !m_tready)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (m_fire)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_fire)
            begin
                out_reg      <= skid_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !m_tready)
            begin
                skid_reg      <= res;
                skid_last_reg <= last;
            end
            else
            begin
                out_reg      <= res;
                out_last_reg <= last;
            end
        end
    end

    assign s_tready = !skid_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_reg.risk_sum, out_reg.low_count, out_reg.is_low,
                       out_reg.centre_level, out_reg.row, out_reg.col};

endmodule

// ===== rtl/glmd_checker.sv =====
// Port-level checks of the grid local minimum detector, bound to the top level.
module glmd_checker
    import glmd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input only stalls when a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // a low point is counted in its own result
    a_low_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18] |-> m_tdata[33:19] != 15'd0)
        else $error("low point with zero count");

    // no low points, no risk
    a_risk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33:19] == 15'd0 |-> m_tdata[51:34] == 18'd0)
        else $error("risk without low points");

endmodule

bind grid_local_minimum_detector glmd_checker u_glmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
